// ===== hdl/r2p_pkg.sv =====
// Shared constants, types and the arctangent table of the rectangular-to-polar converter.
package r2p_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD_BITS    = 4;
  localparam int ANGLE_FRAC    = 30;
  localparam int TABLE_LEN     = 24;
  localparam int SHW           = $clog2(TABLE_LEN);

  // x/y: sign, negation of the most negative input, guard bits, CORDIC growth
  localparam int XW = SAMPLE_WIDTH + GUARD_BITS + 4;
  // angle in 2^-30 rad, |z| < pi + sum of table < 2^33
  localparam int ZW = ANGLE_FRAC + 5;

  localparam int                   GAIN_W   = 24;
  localparam logic [GAIN_W-1:0]    GAIN_Q24 = GAIN_W'(10188014);
  localparam longint               PI_Q30_L = 64'sd3373259426;
  localparam logic signed [ZW-1:0] PI_Q30   = ZW'(PI_Q30_L);

  // phase rounding
  localparam int     PH_SHIFT = ANGLE_FRAC - (SAMPLE_WIDTH - 3);
  localparam int     PH_W     = ZW - PH_SHIFT;
  localparam longint PH_LIM_L = (PI_Q30_L + (64'sd1 <<< (PH_SHIFT - 1))) >>> PH_SHIFT;
  localparam logic signed [ZW-1:0]           PH_HALF  = ZW'(64'sd1 <<< (PH_SHIFT - 1));
  localparam logic signed [PH_W-1:0]         PH_LIM   = PH_W'(PH_LIM_L);
  localparam logic signed [SAMPLE_WIDTH-1:0] PH_LIM_O = SAMPLE_WIDTH'(PH_LIM_L);

  // magnitude scaling
  localparam int MAG_SHIFT = 24 + GUARD_BITS;
  localparam int PROD_W    = (XW - 1) + GAIN_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MW        = SUM_W - MAG_SHIFT;
  localparam logic [SUM_W-1:0] MAG_HALF = SUM_W'(64'd1 << (MAG_SHIFT - 1));

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] real_part;
    logic signed [SAMPLE_WIDTH-1:0] imag_part;
  } in_item_t;

  typedef struct packed {
    logic        [SAMPLE_WIDTH-1:0] magnitude;
    logic signed [SAMPLE_WIDTH-1:0] phase;
  } out_item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  // atan(2^-i) in units of 2^-30 rad, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q30(input logic [SHW-1:0] idx);
    longint v;
    case (idx)
      0:       v = 843314857;
      1:       v = 497837829;
      2:       v = 263043837;
      3:       v = 133525159;
      4:       v = 67021687;
      5:       v = 33543516;
      6:       v = 16775851;
      7:       v = 8388437;
      8:       v = 4194283;
      9:       v = 2097149;
      10:      v = 1048576;
      11:      v = 524288;
      12:      v = 262144;
      13:      v = 131072;
      14:      v = 65536;
      15:      v = 32768;
      16:      v = 16384;
      17:      v = 8192;
      18:      v = 4096;
      19:      v = 2048;
      20:      v = 1024;
      21:      v = 512;
      22:      v = 256;
      23:      v = 128;
      default: v = 0;
    endcase
    return ZW'(v);
  endfunction

endpackage

// ===== hdl/r2p_pre.sv =====
// Input register with pre-rotation into the right half plane.
module r2p_pre (
  input  logic              clk,
  input  logic              rst_n,
  input  r2p_pkg::in_item_t d_i,
  input  logic              vld_i,
  output logic              rdy_o,
  output r2p_pkg::cordic_t  d_o,
  output logic              vld_o,
  input  logic              rdy_i
);

  logic                         vld_r, vld_nxt;
  r2p_pkg::cordic_t             d_r, d_nxt;
  logic signed [r2p_pkg::XW-1:0] re_x, im_x;
  logic                         neg;

  assign rdy_o = !vld_r || rdy_i;

  always_comb begin
    re_x = r2p_pkg::XW'(d_i.real_part);
    im_x = r2p_pkg::XW'(d_i.imag_part);
    neg  = d_i.real_part[r2p_pkg::SAMPLE_WIDTH-1];
    if (neg) begin
      d_nxt.x = (-re_x) <<< r2p_pkg::GUARD_BITS;
      d_nxt.y = (-im_x) <<< r2p_pkg::GUARD_BITS;
      d_nxt.z = d_i.imag_part[r2p_pkg::SAMPLE_WIDTH-1] ? -r2p_pkg::PI_Q30 : r2p_pkg::PI_Q30;
    end else begin
      d_nxt.x = re_x <<< r2p_pkg::GUARD_BITS;
      d_nxt.y = im_x <<< r2p_pkg::GUARD_BITS;
      d_nxt.z = '0;
    end
    d_nxt.zero = (d_i.real_part == '0) && (d_i.imag_part == '0);
    vld_nxt    = rdy_o ? vld_i : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      d_r <= d_nxt;
    end
  end

  assign d_o   = d_r;
  assign vld_o = vld_r;

endmodule

// ===== hdl/r2p_cell.sv =====
// One CORDIC vectoring micro-rotation with its own pipeline register.
module r2p_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [r2p_pkg::SHW-1:0] shift,
  input  r2p_pkg::cordic_t        d_i,
  input  logic                    vld_i,
  output logic                    rdy_o,
  output r2p_pkg::cordic_t        d_o,
  output logic                    vld_o,
  input  logic                    rdy_i
);

  logic                          vld_r, vld_nxt;
  r2p_pkg::cordic_t              d_r, d_nxt;
  logic signed [r2p_pkg::XW-1:0] xs, ys;
  logic signed [r2p_pkg::ZW-1:0] ang;

  assign rdy_o = !vld_r || rdy_i;

  always_comb begin
    xs    = d_i.x >>> shift;
    ys    = d_i.y >>> shift;
    ang   = r2p_pkg::atan_q30(shift);
    d_nxt = d_i;
    if (!d_i.y[r2p_pkg::XW-1]) begin
      d_nxt.x = d_i.x + ys;
      d_nxt.y = d_i.y - xs;
      d_nxt.z = d_i.z + ang;
    end else begin
      d_nxt.x = d_i.x - ys;
      d_nxt.y = d_i.y + xs;
      d_nxt.z = d_i.z - ang;
    end
    vld_nxt = rdy_o ? vld_i : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      d_r <= d_nxt;
    end
  end

  assign d_o   = d_r;
  assign vld_o = vld_r;

  // x starts in the right half plane and only grows in vectoring mode
  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> !d_r.x[r2p_pkg::XW-1])
    else $error("cordic x went negative");

endmodule

// ===== hdl/r2p_post.sv =====
// Gain compensation multiply, magnitude/phase rounding and saturation, output register.
module r2p_post (
  input  logic               clk,
  input  logic               rst_n,
  input  r2p_pkg::cordic_t   d_i,
  input  logic               vld_i,
  output logic               rdy_o,
  output r2p_pkg::out_item_t d_o,
  output logic               vld_o,
  input  logic               rdy_i
);

  // stage A: multiply and phase rounding
  logic                                    va_r, va_nxt, rdy_a;
  logic [r2p_pkg::PROD_W-1:0]              prod_r, prod_nxt;
  logic signed [r2p_pkg::SAMPLE_WIDTH-1:0] ph_r, ph_nxt;
  logic [r2p_pkg::XW-2:0]                  xpos;
  logic signed [r2p_pkg::ZW-1:0]           z_rnd;
  logic signed [r2p_pkg::PH_W-1:0]         ph_full, ph_sat;

  // stage B: magnitude rounding, output register
  logic                                    vb_r, vb_nxt, rdy_b;
  r2p_pkg::out_item_t                      ob_r, ob_nxt;
  logic [r2p_pkg::SUM_W-1:0]               sum;
  logic [r2p_pkg::MW-1:0]                  mag_full;

  assign rdy_b = !vb_r || rdy_i;
  assign rdy_a = !va_r || rdy_b;
  assign rdy_o = rdy_a;

  always_comb begin
    xpos     = d_i.x[r2p_pkg::XW-1] ? '0 : d_i.x[r2p_pkg::XW-2:0];
    prod_nxt = r2p_pkg::PROD_W'(xpos) * r2p_pkg::PROD_W'(r2p_pkg::GAIN_Q24);
    z_rnd    = d_i.z + r2p_pkg::PH_HALF;
    ph_full  = r2p_pkg::PH_W'(z_rnd >>> r2p_pkg::PH_SHIFT);
    if (ph_full > r2p_pkg::PH_LIM) begin
      ph_sat = r2p_pkg::PH_LIM;
    end else if (ph_full < -r2p_pkg::PH_LIM) begin
      ph_sat = -r2p_pkg::PH_LIM;
    end else begin
      ph_sat = ph_full;
    end
    // origin: no angle defined, report zero
    if (d_i.zero) begin
      prod_nxt = '0;
      ph_nxt   = '0;
    end else begin
      ph_nxt   = r2p_pkg::SAMPLE_WIDTH'(ph_sat);
    end
    va_nxt = rdy_a ? vld_i : va_r;
  end

  always_comb begin
    sum      = {1'b0, prod_r} + r2p_pkg::MAG_HALF;
    mag_full = sum[r2p_pkg::SUM_W-1:r2p_pkg::MAG_SHIFT];
    if (|mag_full[r2p_pkg::MW-1:r2p_pkg::SAMPLE_WIDTH]) begin
      ob_nxt.magnitude = '1;
    end else begin
      ob_nxt.magnitude = mag_full[r2p_pkg::SAMPLE_WIDTH-1:0];
    end
    ob_nxt.phase = ph_r;
    vb_nxt       = rdy_b ? va_r : vb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_a) begin
      prod_r <= prod_nxt;
      ph_r   <= ph_nxt;
    end
    if (va_r && rdy_b) begin
      ob_r <= ob_nxt;
    end
  end

  assign d_o   = ob_r;
  assign vld_o = vb_r;

endmodule

// ===== hdl/rect_to_polar_converter.sv =====
// Top level of the rectangular-to-polar converter: input stage, CORDIC cell row, output stage.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one complex sample per
//   transaction, real_part and imag_part as signed Q1.15.
//   Output channel (out_valid / out_stall / out_data): one result per input
//   transaction, magnitude as unsigned Q1.15 (gain compensated) and phase
//   atan2(imag, real) as signed Q3.13 radians, saturated to +-pi.
//   The origin (both parts zero) returns magnitude 0 and phase 0.
// Pipeline: 19 register stages (1 pre-rotation stage, 16 CORDIC cells,
//   multiply stage, output register). The accepting edge loads the first one,
//   and the result passes through the others in order before out_valid rises.
// Throughput: one transaction per cycle while out_stall is low; every stage is a register
//   with its own valid bit, so the row of CORDIC cells sets the latency, not the rate.
// Stall: out_stall holds the output register; stages behind it keep filling
//   until each holds an item, and only then in_stall rises. Bubbles collapse.
// Reset: rst_n (synchronous) clears every valid bit; no results in flight
//   survive it and the block accepts input again in the next cycle.
module rect_to_polar_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  r2p_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output r2p_pkg::out_item_t out_data
);

  localparam int NS = r2p_pkg::CORDIC_STAGES;

  // link k feeds cell k; link NS feeds the output stage
  r2p_pkg::cordic_t link_d   [NS+1];
  logic             link_vld [NS+1];
  logic             link_rdy [NS+1];
  logic             pre_rdy;

  r2p_pre u_pre (
    .clk   (clk),
    .rst_n (rst_n),
    .d_i   (in_data),
    .vld_i (in_valid),
    .rdy_o (pre_rdy),
    .d_o   (link_d[0]),
    .vld_o (link_vld[0]),
    .rdy_i (link_rdy[0])
  );

  assign in_stall = !pre_rdy;

  // row of identical micro-rotation cells; each cell's shift is its index
  for (genvar k = 0; k < NS; k++) begin : g_cell
    r2p_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (r2p_pkg::SHW'(k)),
      .d_i   (link_d[k]),
      .vld_i (link_vld[k]),
      .rdy_o (link_rdy[k]),
      .d_o   (link_d[k+1]),
      .vld_o (link_vld[k+1]),
      .rdy_i (link_rdy[k+1])
    );
  end

  r2p_post u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .d_i   (link_d[NS]),
    .vld_i (link_vld[NS]),
    .rdy_o (link_rdy[NS]),
    .d_o   (out_data),
    .vld_o (out_valid),
    .rdy_i (!out_stall)
  );

  // input can only back up when the whole pipe, output register included, is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  // phase saturation keeps every result within +-pi
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.phase <= r2p_pkg::PH_LIM_O) &&
                  (out_data.phase >= -r2p_pkg::PH_LIM_O))
    else $error("phase outside +-pi");

  // a freshly reset pipe is empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

endmodule
